[sv/lzw_pkg.sv]
package lzw_pkg;

    // Fixed field widths of the symbol and code ports
    localparam int SYM_W  = 8;
    localparam int CODE_W = 13;

endpackage

[sv/lzw_encoder_top.sv]
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_ready    | i_symbol, i_last_symbol
// output  | out       | o_out_valid / i_out_ready  | o_code, o_last_code
//
// A symbol that extends the prefix goes through accept, child-table read
// in the first cell, pair read and check in the second cell.
// A symbol that ends a string also passes the emit state, which waits on the
// output register; a last symbol adds the flush state for the flush code.
// The two-cell probe chain and the single output register set these steps.
// Reset is synchronous, active low; the dictionary banks are not cleared,
// a child pointer is trusted only after the pair bank confirms it.
// A stalled output register holds the encoder only when a new code is due.
module lzw_encoder_top #(
    parameter int DICT_SIZE     = 4096,
    parameter int ALPHABET_SIZE = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [lzw_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_last_symbol,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [lzw_pkg::CODE_W-1:0] o_code,
    output logic                      o_last_code
);

    localparam int IDX_W  = $clog2(DICT_SIZE);
    localparam int SB_W   = $clog2(ALPHABET_SIZE);
    localparam int PFX_W  = (IDX_W > SB_W) ? IDX_W : SB_W;
    localparam int KEY_W  = PFX_W + SB_W;
    localparam int CNT_W  = $clog2(DICT_SIZE + 1);
    localparam int SYMX_W = lzw_pkg::SYM_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;

    logic [2:0]       r_state, n_state;
    logic [PFX_W-1:0] r_prefix, n_prefix;
    logic             r_pvalid, n_pvalid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SB_W-1:0]  r_sym, n_sym;
    logic             r_last, n_last;

    logic                      r_out_valid, n_out_valid;
    logic [lzw_pkg::CODE_W-1:0] r_code, n_code;
    logic                      r_last_code, n_last_code;

    logic              in_accept;
    logic              in_range;
    logic              out_free;
    logic [PFX_W:0]    code_sum;
    logic [KEY_W-1:0]  launch_key;
    logic [KEY_W-1:0]  held_key;
    logic              dict_open;
    logic              wr_en;

    logic              tok0_valid;
    logic [KEY_W-1:0]  tok0_key;
    logic [IDX_W-1:0]  rd0_cand;
    logic              tok1_valid;
    logic [KEY_W+IDX_W-1:0] tok1_data;
    logic [KEY_W-1:0]  rd1_pair;
    logic [KEY_W-1:0]  tok1_key;
    logic [IDX_W-1:0]  tok1_cand;
    logic              hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_range   = ({1'b0, i_symbol} < SYMX_W'(ALPHABET_SIZE));
    assign out_free   = !r_out_valid || i_out_ready;
    assign code_sum   = {1'b0, r_prefix} + (PFX_W + 1)'(1);
    assign launch_key = {r_prefix, i_symbol[SB_W-1:0]};
    assign held_key   = {r_prefix, r_sym};
    assign dict_open  = (r_count < CNT_W'(DICT_SIZE));
    assign wr_en      = (r_state == S_EMIT) && out_free && dict_open;

    // cell 0: child pointer table, addressed by (prefix, symbol)
    lzw_cell #(
        .ADDR_W (KEY_W),
        .DATA_W (IDX_W),
        .TOK_W  (KEY_W)
    ) u_cell_child (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (in_accept && in_range && r_pvalid),
        .i_tok_data  (launch_key),
        .i_rd_addr   (launch_key),
        .i_wr_en     (wr_en),
        .i_wr_addr   (held_key),
        .i_wr_data   (r_count[IDX_W-1:0]),
        .o_tok_valid (tok0_valid),
        .o_tok_data  (tok0_key),
        .o_rd_data   (rd0_cand)
    );

    // cell 1: pair bank, confirms the candidate entry holds this key
    lzw_cell #(
        .ADDR_W (IDX_W),
        .DATA_W (KEY_W),
        .TOK_W  (KEY_W + IDX_W)
    ) u_cell_pair (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok0_valid),
        .i_tok_data  ({tok0_key, rd0_cand}),
        .i_rd_addr   (rd0_cand),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_count[IDX_W-1:0]),
        .i_wr_data   (held_key),
        .o_tok_valid (tok1_valid),
        .o_tok_data  (tok1_data),
        .o_rd_data   (rd1_pair)
    );

    assign tok1_key  = tok1_data[KEY_W+IDX_W-1:IDX_W];
    assign tok1_cand = tok1_data[IDX_W-1:0];
    assign hit = (CNT_W'(tok1_cand) >= CNT_W'(ALPHABET_SIZE))
              && (CNT_W'(tok1_cand) < r_count)
              && (rd1_pair == tok1_key);

    always_comb begin
        n_state     = r_state;
        n_prefix    = r_prefix;
        n_pvalid    = r_pvalid;
        n_count     = r_count;
        n_sym       = r_sym;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_code      = r_code;
        n_last_code = r_last_code;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_sym  = i_symbol[SB_W-1:0];
                    n_last = i_last_symbol;
                    if (in_range && r_pvalid) begin
                        n_state = S_PROBE;
                    end else begin
                        if (in_range) begin
                            n_prefix = PFX_W'(i_symbol[SB_W-1:0]);
                            n_pvalid = 1'b1;
                        end
                        if (i_last_symbol) begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_PROBE: begin
                if (tok1_valid) begin
                    if (hit) begin
                        n_prefix = PFX_W'(tok1_cand);
                        n_state  = r_last ? S_FLUSH : S_IDLE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // emit the prefix code plus one, add the new pair while the dictionary has room, restart at the symbol
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_code      = lzw_pkg::CODE_W'(code_sum);
                    n_last_code = 1'b0;
                    if (dict_open) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_prefix = PFX_W'(r_sym);
                    n_state  = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!r_pvalid) begin
                    n_prefix = '0;
                    n_state  = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_code      = lzw_pkg::CODE_W'(code_sum);
                    n_last_code = 1'b1;
                    n_prefix    = '0;
                    n_pvalid    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prefix    <= '0;
            r_pvalid    <= 1'b0;
            r_count     <= CNT_W'(ALPHABET_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prefix    <= n_prefix;
            r_pvalid    <= n_pvalid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym       <= n_sym;
        r_last      <= n_last;
        r_code      <= n_code;
        r_last_code <= n_last_code;
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_code;
    assign o_last_code = r_last_code;

endmodule

[sv/lzw_ram.sv]
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lzw_cell.sv]
// One probe cell: a dictionary bank with registered read, plus the token
// register that carries the probe on to the next cell.
module lzw_cell #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8,
    parameter int TOK_W  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  logic [TOK_W-1:0]  i_tok_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_tok_valid,
    output logic [TOK_W-1:0]  o_tok_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic             r_tok_valid;
    logic [TOK_W-1:0] r_tok_data;

    lzw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 ** ADDR_W)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (o_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    // token payload travels alongside the read, so it lines up with the data
    always_ff @(posedge i_clk) begin
        r_tok_data <= i_tok_data;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_data  = r_tok_data;

endmodule
